/* hw/rtl/tracker_voice_event_decoder_macros.svh */
// Assertion macros for the tracker voice event decoder
`ifndef TRACKER_VOICE_EVENT_DECODER_MACROS_SVH
`define TRACKER_VOICE_EVENT_DECODER_MACROS_SVH

`ifndef SYNTH

// Holds on every clock edge outside reset.
`define TVD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tracker voice decoder assertion failed");

// Consequent holds in the cycle after the antecedent.
`define TVD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tracker voice decoder assertion failed");

`else

`define TVD_ASSERT(label, prop)
`define TVD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hw/rtl/tvd_pkg.sv */
// Shared types, constants and helpers for the tracker voice event decoder
package tvd_pkg;

  localparam int unsigned RowBits = 10;

  localparam logic [7:0] CmdNote  = 8'd1;
  localparam logic [7:0] CmdInstr = 8'd2;
  localparam logic [8:0] EffBias  = 9'd3;

  // One burst of rows caused by a single input word
  typedef struct packed {
    logic               valid;
    logic [3:0]         count;
    logic [RowBits-1:0] row;
    logic               end_voice;
    logic               unsup;
    logic               note_p;
    logic [7:0]         note_v;
    logic               inst_p;
    logic [7:0]         inst_v;
    logic               eff_p;
    logic [7:0]         eff_cmd;
    logic [7:0]         eff_par;
  } tvd_desc_t;

  // v / 12 as (v * 171) >> 11, exact for all 8-bit v
  function automatic logic [4:0] div12(input logic [7:0] v);
    logic [15:0] p;
    begin
      p = {8'd0, v} * 16'd171;
      div12 = p[15:11];
    end
  endfunction

  function automatic logic [3:0] mod12(input logic [7:0] v);
    logic [4:0] q;
    logic [7:0] r;
    begin
      q = div12(v);
      r = v - 8'({3'd0, q} * 8'd12);
      mod12 = r[3:0];
    end
  endfunction

endpackage

/* hw/rtl/tracker_voice_event_decoder.sv */
// Top level of the tracker voice event decoder
//
// Input channel: one record byte per word (data_byte_i, first_byte_i), taken
// when in_valid_i is high and in_stall_o low. A word with first_byte_i set
// starts a voice record; the four length bytes are skipped.
// Output channel: one row word per beat, taken when out_valid_o is high and
// out_stall_i low; last_o marks the final row caused by one input word.
// Config: cfg_data_i sets format_is_mod on cfg_valid_i; cfg_ready_o is
// always high. Write it only while the block is idle.
// Path: a row goes through the burst register, then the output register.
// Throughput: one input word per cycle while in_stall_o is low; a word that
// expands to N rows holds the input until its last row moves, as the burst
// register hands one row per cycle to the output register while it is free.
// The burst register lets the next word be taken while a finished row waits.
// Reset: parser returns to idle, row counter and latches clear, no rows are
// pending, format_is_mod reads 1.
// Receiver stall: the output row holds; the burst register fills and then
// in_stall_o rises until the stall clears.
`include "tracker_voice_event_decoder_macros.svh"

module tracker_voice_event_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              first_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [9:0]        row_number_o,
  output logic              note_present_o,
  output logic [4:0]        octave_o,
  output logic [3:0]        pitch_class_o,
  output logic              instrument_present_o,
  output logic [8:0]        instrument_number_o,
  output logic              effect_present_o,
  output logic signed [8:0] effect_code_o,
  output logic [7:0]        effect_param_o,
  output logic              end_of_voice_o,
  output logic              unsupported_o,
  output logic              last_o
);
  import tvd_pkg::*;

  logic               fmt_mod_q;
  logic               in_fire;
  tvd_desc_t          desc;

  logic               burst_v_q;
  tvd_desc_t          burst_q;
  logic               out_free;
  logic               move;
  logic               burst_done;

  logic               out_v_q;
  logic [RowBits-1:0] row_q;
  logic               note_p_q;
  logic [4:0]         oct_q;
  logic [3:0]         pc_q;
  logic               inst_p_q;
  logic [8:0]         inst_num_q;
  logic               eff_p_q;
  logic [8:0]         eff_code_q;
  logic [7:0]         eff_par_q;
  logic               end_q;
  logic               unsup_q;
  logic               last_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_mod_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fmt_mod_q <= cfg_data_i;
    end
  end

  assign out_free   = !out_v_q || !out_stall_i;
  assign move       = burst_v_q && out_free;
  assign burst_done = move && (burst_q.count == 4'd1);
  assign in_stall_o = burst_v_q && !burst_done;
  assign in_fire    = in_valid_i && !in_stall_o;

  tvd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fmt_mod_i   (fmt_mod_q),
    .fire_i      (in_fire),
    .data_byte_i (data_byte_i),
    .first_byte_i(first_byte_i),
    .desc_o      (desc)
  );

  // burst register: rows still to be handed to the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_v_q <= 1'b0;
    end else if (in_fire && desc.valid) begin
      burst_v_q <= 1'b1;
    end else if (burst_done) begin
      burst_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && desc.valid) begin
      burst_q <= desc;
    end else if (move) begin
      burst_q.count <= burst_q.count - 4'd1;
      burst_q.row   <= burst_q.row + RowBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (move) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      row_q      <= burst_q.row;
      note_p_q   <= burst_q.note_p;
      oct_q      <= burst_q.note_p ? div12(burst_q.note_v) : 5'd0;
      pc_q       <= burst_q.note_p ? mod12(burst_q.note_v) : 4'd0;
      inst_p_q   <= burst_q.inst_p;
      inst_num_q <= burst_q.inst_p ? ({1'b0, burst_q.inst_v} + 9'd1) : 9'd0;
      eff_p_q    <= burst_q.eff_p;
      eff_code_q <= burst_q.eff_p ? ({1'b0, burst_q.eff_cmd} - EffBias) : 9'd0;
      eff_par_q  <= burst_q.eff_p ? burst_q.eff_par : 8'd0;
      end_q      <= burst_q.end_voice;
      unsup_q    <= burst_q.unsup;
      last_q     <= (burst_q.count == 4'd1);
    end
  end

  assign out_valid_o          = out_v_q;
  assign row_number_o         = row_q;
  assign note_present_o       = note_p_q;
  assign octave_o             = oct_q;
  assign pitch_class_o        = pc_q;
  assign instrument_present_o = inst_p_q;
  assign instrument_number_o  = inst_num_q;
  assign effect_present_o     = eff_p_q;
  assign effect_code_o        = $signed(eff_code_q);
  assign effect_param_o       = eff_par_q;
  assign end_of_voice_o       = end_q;
  assign unsupported_o        = unsup_q;
  assign last_o               = last_q;

  // a pending burst always has rows left
  `TVD_ASSERT(a_burst_nonempty, !burst_v_q || (burst_q.count != 4'd0))
  // a row that is not the last of its word leaves more rows behind it
  `TVD_ASSERT(a_more_rows_pending, !(out_v_q && !last_q) || burst_v_q)
  // rows of one burst number consecutively
  `TVD_ASSERT_NEXT(a_row_seq, out_v_q && !out_stall_i && !last_q, row_q == $past(row_q) + RowBits'(1))

endmodule

/* hw/rtl/tvd_parser.sv */
// Voice record parser: phase tracking, latches and row counter
module tvd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fmt_mod_i,
  input  logic                fire_i,
  input  logic [7:0]          data_byte_i,
  input  logic                first_byte_i,
  output tvd_pkg::tvd_desc_t  desc_o
);
  import tvd_pkg::*;

  localparam logic [2:0] PhIdle    = 3'd0;
  localparam logic [2:0] PhPrefix  = 3'd1;
  localparam logic [2:0] PhControl = 3'd2;
  localparam logic [2:0] PhCmd     = 3'd3;
  localparam logic [2:0] PhParam   = 3'd4;

  logic [2:0]         phase_q, phase_d;
  logic [1:0]         skip_q, skip_d;
  logic [3:0]         pairs_q, pairs_d;
  logic [3:0]         rep_q, rep_d;
  logic [7:0]         cmd_q, cmd_d;
  logic               note_p_q, note_p_d;
  logic [7:0]         note_q, note_d;
  logic               inst_p_q, inst_p_d;
  logic [7:0]         inst_q, inst_d;
  logic               eff_p_q, eff_p_d;
  logic [7:0]         eff_cmd_q, eff_cmd_d;
  logic [7:0]         eff_par_q, eff_par_d;
  logic [RowBits-1:0] row_q, row_d;
  logic [3:0]         lo, hi;
  tvd_desc_t          desc;

  assign lo = data_byte_i[3:0];
  assign hi = data_byte_i[7:4];

  always_comb begin
    phase_d   = phase_q;
    skip_d    = skip_q;
    pairs_d   = pairs_q;
    rep_d     = rep_q;
    cmd_d     = cmd_q;
    note_p_d  = note_p_q;
    note_d    = note_q;
    inst_p_d  = inst_p_q;
    inst_d    = inst_q;
    eff_p_d   = eff_p_q;
    eff_cmd_d = eff_cmd_q;
    eff_par_d = eff_par_q;
    row_d     = row_q;
    desc      = '0;
    desc.row  = row_q;

    if (first_byte_i) begin
      pairs_d   = '0;
      rep_d     = '0;
      cmd_d     = '0;
      note_p_d  = 1'b0;
      note_d    = '0;
      inst_p_d  = 1'b0;
      inst_d    = '0;
      eff_p_d   = 1'b0;
      eff_cmd_d = '0;
      eff_par_d = '0;
      row_d     = '0;
      if (!fmt_mod_i) begin
        phase_d     = PhIdle;
        skip_d      = '0;
        desc.valid  = 1'b1;
        desc.count  = 4'd1;
        desc.unsup  = 1'b1;
        desc.row    = '0;
      end else begin
        phase_d = PhPrefix;
        skip_d  = 2'd3;
      end
    end else begin
      unique case (phase_q)
        PhPrefix: begin
          skip_d = skip_q - 2'd1;
          if (skip_q == 2'd1) begin
            phase_d = PhControl;
          end
        end
        PhControl: begin
          note_p_d  = 1'b0;
          note_d    = '0;
          inst_p_d  = 1'b0;
          inst_d    = '0;
          eff_p_d   = 1'b0;
          eff_cmd_d = '0;
          eff_par_d = '0;
          if (data_byte_i == 8'd0) begin
            desc.valid     = 1'b1;
            desc.count     = 4'd1;
            desc.end_voice = 1'b1;
            phase_d        = PhIdle;
          end else if (lo == 4'd0) begin
            // empty rows only
            desc.valid = 1'b1;
            desc.count = hi;
            row_d      = row_q + RowBits'(hi);
          end else begin
            pairs_d = lo;
            rep_d   = hi;
            phase_d = PhCmd;
          end
        end
        PhCmd: begin
          cmd_d   = data_byte_i;
          phase_d = PhParam;
        end
        PhParam: begin
          if (cmd_q == CmdNote) begin
            note_p_d = 1'b1;
            note_d   = data_byte_i;
          end else if (cmd_q == CmdInstr) begin
            inst_p_d = 1'b1;
            inst_d   = data_byte_i;
          end else begin
            eff_p_d   = 1'b1;
            eff_cmd_d = cmd_q;
            eff_par_d = data_byte_i;
          end
          pairs_d = pairs_q - 4'd1;
          if (pairs_q != 4'd1) begin
            phase_d = PhCmd;
          end else begin
            phase_d      = PhControl;
            desc.valid   = 1'b1;
            desc.count   = rep_q;
            desc.note_p  = note_p_d;
            desc.note_v  = note_d;
            desc.inst_p  = inst_p_d;
            desc.inst_v  = inst_d;
            desc.eff_p   = eff_p_d;
            desc.eff_cmd = eff_cmd_d;
            desc.eff_par = eff_par_d;
            row_d        = row_q + RowBits'(rep_q);
          end
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
    end
    // a zero repeat emits nothing
    if (desc.count == 4'd0) begin
      desc.valid = 1'b0;
    end
  end

  assign desc_o = desc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      skip_q    <= '0;
      pairs_q   <= '0;
      rep_q     <= '0;
      cmd_q     <= '0;
      note_p_q  <= 1'b0;
      note_q    <= '0;
      inst_p_q  <= 1'b0;
      inst_q    <= '0;
      eff_p_q   <= 1'b0;
      eff_cmd_q <= '0;
      eff_par_q <= '0;
      row_q     <= '0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      skip_q    <= skip_d;
      pairs_q   <= pairs_d;
      rep_q     <= rep_d;
      cmd_q     <= cmd_d;
      note_p_q  <= note_p_d;
      note_q    <= note_d;
      inst_p_q  <= inst_p_d;
      inst_q    <= inst_d;
      eff_p_q   <= eff_p_d;
      eff_cmd_q <= eff_cmd_d;
      eff_par_q <= eff_par_d;
      row_q     <= row_d;
    end
  end

endmodule
